### hdl/swtm_pkg.sv
// shared types and constants for the sliding window trimmed mean block
// used by swtm_ctrl, swtm_dp and sliding_window_trimmed_mean; no dependencies
package swtm_pkg;

	localparam int SAMPLE_W = 18;
	localparam int TDATA_W  = 24;

	// controller to datapath commands, at most one high per cycle
	typedef struct packed {
		logic load;   // shift new sample into window, clear accumulator
		logic step;   // rank window head, rotate window
		logic mul;    // reciprocal multiply of the sum
		logic quo;    // quotient estimate and remainder
		logic fin;    // corrected quotient into output register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

### hdl/swtm_ctrl.sv
// controller state machine of the sliding window trimmed mean block
// sequences load, ranking, divide and output; depends on swtm_pkg
module swtm_ctrl #(
	parameter int WINDOW_SIZE = 9
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  swtm_pkg::status_t              status,
	output swtm_pkg::cmd_t                 cmd,
	output logic [$clog2(WINDOW_SIZE)-1:0] step_idx
);

	localparam int IDX_W = $clog2(WINDOW_SIZE);
	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(WINDOW_SIZE - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RANK  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_QUO   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]       state_q;
	logic [2:0]       state_nxt;
	logic [IDX_W-1:0] cnt_q;

	assign step_idx = cnt_q;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_RANK;
				end
			end
			ST_RANK: begin
				cmd.step = 1'b1;
				if (cnt_q == LAST_STEP) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_QUO;
			end
			ST_QUO: begin
				cmd.quo   = 1'b1;
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.fin   = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
		end
	end

endmodule

### hdl/swtm_dp.sv
// datapath of the sliding window trimmed mean block: sample window, rank
// pipeline, middle third accumulator, constant divider, output register; uses swtm_pkg
module swtm_dp #(
	parameter int WINDOW_SIZE = 9
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [swtm_pkg::SAMPLE_W-1:0]     sample,
	input  swtm_pkg::cmd_t                    cmd,
	input  logic [$clog2(WINDOW_SIZE)-1:0]    step_idx,
	output swtm_pkg::status_t                 status,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [swtm_pkg::SAMPLE_W-1:0]     mean
);

	localparam int SW     = swtm_pkg::SAMPLE_W;
	localparam int TRIM   = WINDOW_SIZE / 3;
	localparam int IDX_W  = $clog2(WINDOW_SIZE);
	localparam int SUM_W  = SW + $clog2(TRIM);
	localparam int M_W    = SUM_W + 1;
	localparam int PROD_W = SUM_W + M_W;
	localparam logic [M_W-1:0]   RECIP  = M_W'((64'd1 << SUM_W) / TRIM);
	localparam logic [IDX_W:0]   N_EXT  = (IDX_W + 1)'(WINDOW_SIZE);
	localparam logic [IDX_W-1:0] LO_RNK = IDX_W'(TRIM);
	localparam logic [IDX_W-1:0] HI_RNK = IDX_W'(2 * TRIM);

	logic [SW-1:0]          win_q [WINDOW_SIZE];
	logic [WINDOW_SIZE-2:0] flags_s1;
	logic [SW-1:0]          cand_s1;
	logic                   vld_s1;
	logic [WINDOW_SIZE-2:0] flags;
	logic [IDX_W:0]         tie_thr;
	logic [IDX_W-1:0]       rank;
	logic [SUM_W-1:0]       acc_q;
	logic [PROD_W-1:0]      prod_q;
	logic [SW-1:0]          q_est;
	logic [SUM_W-1:0]       q_times_t;
	logic [SUM_W-1:0]       diff;
	logic [SW-1:0]          quot_q;
	logic [SW-1:0]          mean_q;
	logic                   valid_q;

	// head entry at step c is original slot c; an equal tap ranks lower
	// when its original slot is below c, i.e. tap k >= N - c
	assign tie_thr = N_EXT - {1'b0, step_idx};

	always_comb begin
		for (int k = 1; k < WINDOW_SIZE; k++) begin
			flags[k-1] = (win_q[k] < win_q[0]) ||
				((win_q[k] == win_q[0]) && ((IDX_W + 1)'(k) >= tie_thr));
		end
	end

	always_comb begin
		rank = '0;
		for (int k = 0; k < WINDOW_SIZE - 1; k++) begin
			rank = rank + IDX_W'(flags_s1[k]);
		end
	end

	assign q_est     = prod_q[SUM_W +: SW];
	assign q_times_t = {{(SUM_W - SW){1'b0}}, quot_q} * SUM_W'(TRIM);
	assign diff      = acc_q - q_times_t;

	// window: load shifts new sample in at the head and drops the oldest,
	// a step rotates by one so N steps bring the order back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW_SIZE; k++) begin
				win_q[k] <= '0;
			end
		end else if (cmd.load) begin
			win_q[0] <= sample;
			for (int k = 1; k < WINDOW_SIZE; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end else if (cmd.step) begin
			for (int k = 0; k < WINDOW_SIZE - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[WINDOW_SIZE-1] <= win_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.step;
			if (cmd.fin) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		flags_s1 <= flags;
		cand_s1  <= win_q[0];
		if (cmd.load) begin
			acc_q <= '0;
		end else if (vld_s1 && rank >= LO_RNK && rank < HI_RNK) begin
			acc_q <= acc_q + SUM_W'(cand_s1);
		end
		if (cmd.mul) begin
			prod_q <= {{M_W{1'b0}}, acc_q} * {{SUM_W{1'b0}}, RECIP};
		end
		// estimate is low by at most one, the remainder fixes it
		if (cmd.quo) begin
			quot_q <= q_est;
		end
		if (cmd.fin) begin
			mean_q <= quot_q + SW'(diff >= SUM_W'(TRIM));
		end
	end

	assign status.out_free = !valid_q || m_tready;
	assign m_tvalid        = valid_q;
	assign mean            = mean_q;

endmodule

### hdl/sliding_window_trimmed_mean.sv
// sliding window trimmed mean of pressure samples, top level
// sequence: an accepted item runs the ranking pass, a drain state, the multiply, the
// quotient estimate and the final correction, which waits for a free output register
// ranking rotates the window once per cycle; a new item waits for the return to idle
// an item is taken while the previous result still waits in the output register
// reset: asynchronous active low, clears the window to zeros and the controller
module sliding_window_trimmed_mean #(
	parameter int WINDOW_SIZE = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [swtm_pkg::TDATA_W-1:0] s_tdata,  // [17:0] pressure_sample
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [swtm_pkg::TDATA_W-1:0] m_tdata   // [17:0] trimmed_mean
);

	swtm_pkg::cmd_t                  cmd;
	swtm_pkg::status_t               status;
	logic [$clog2(WINDOW_SIZE)-1:0]  step_idx;
	logic [swtm_pkg::SAMPLE_W-1:0]   mean;

	swtm_ctrl #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd),
		.step_idx (step_idx)
	);

	swtm_dp #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (s_tdata[swtm_pkg::SAMPLE_W-1:0]),
		.cmd      (cmd),
		.step_idx (step_idx),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.mean     (mean)
	);

	assign m_tdata = {{(swtm_pkg::TDATA_W - swtm_pkg::SAMPLE_W){1'b0}}, mean};

endmodule

### dv/tb_top.sv
// self-checking bench for sliding_window_trimmed_mean: a directed table, then random samples
// expected means: typed table values, else a window model; uses swtm_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_top;

	localparam int SAMPLE_W   = swtm_pkg::SAMPLE_W;
	localparam int TDATA_W    = swtm_pkg::TDATA_W;
	localparam int WIN        = 9;
	localparam int TRIM       = WIN / 3;
	localparam int CYCLE_CAP  = 400000;
	localparam int HOLD_LEN   = 200;
	localparam int N_DIR      = 24;
	localparam int PHASE_LEN  = 205;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	typedef struct {
		logic [SAMPLE_W-1:0] smp;
		bit                  typed;
		logic [SAMPLE_W-1:0] mean;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;

	logic [SAMPLE_W-1:0] window_model [WIN];
	int unsigned         wr_slot;
	logic [SAMPLE_W-1:0] mean_q [$];
	int                  mismatch_count;
	int                  tx_idle_pct;
	int                  rx_stall_pct;
	bit                  rx_hold_req;
	int                  drift_base;

	// window full of max samples, then zeros pushing six back out, then rows checked by the model
	dir_row_t dir_tab [N_DIR] = '{
		'{18'd0,      1'b1, 18'd0},
		'{SAMPLE_MAX, 1'b1, 18'd0},
		'{SAMPLE_MAX, 1'b1, 18'd0},
		'{SAMPLE_MAX, 1'b1, 18'd0},
		'{SAMPLE_MAX, 1'b1, 18'd87381},
		'{SAMPLE_MAX, 1'b1, 18'd174762},
		'{SAMPLE_MAX, 1'b1, 18'd262143},
		'{SAMPLE_MAX, 1'b1, 18'd262143},
		'{SAMPLE_MAX, 1'b1, 18'd262143},
		'{SAMPLE_MAX, 1'b1, 18'd262143},
		'{18'd0,      1'b1, 18'd262143},
		'{18'd0,      1'b1, 18'd262143},
		'{18'd0,      1'b1, 18'd262143},
		'{18'd0,      1'b1, 18'd174762},
		'{18'd0,      1'b1, 18'd87381},
		'{18'd0,      1'b1, 18'd0},
		'{18'h2AAAA,  1'b0, 18'd0},
		'{18'h15555,  1'b0, 18'd0},
		'{18'h00001,  1'b0, 18'd0},
		'{18'h20000,  1'b0, 18'd0},
		'{18'h3FFFE,  1'b0, 18'd0},
		'{18'h12345,  1'b0, 18'd0},
		'{18'h12345,  1'b0, 18'd0},
		'{18'h12345,  1'b0, 18'd0}
	};

	sliding_window_trimmed_mean #(
		.WINDOW_SIZE(WIN)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// writes the sample into the model window and returns the middle third mean
	function automatic logic [SAMPLE_W-1:0] window_push_mean(input logic [SAMPLE_W-1:0] smp);
		logic [SAMPLE_W-1:0] ordered [WIN];
		logic [SAMPLE_W-1:0] tmp;
		logic [31:0]         sum;
		sum = '0;
		if (wr_slot >= WIN)
			wr_slot = 0;
		window_model[wr_slot] = smp;
		wr_slot = (wr_slot + 1 >= WIN) ? 0 : wr_slot + 1;
		for (int i = 0; i < WIN; i++)
			ordered[i] = window_model[i];
		for (int i = 0; i < WIN - 1; i++)
			for (int j = 0; j < WIN - 1 - i; j++)
				if (ordered[j] > ordered[j+1]) begin
					tmp          = ordered[j];
					ordered[j]   = ordered[j+1];
					ordered[j+1] = tmp;
				end
		for (int i = TRIM; i < 2 * TRIM; i++)
			sum += ordered[i];
		return SAMPLE_W'(sum / TRIM);
	endfunction

	// mostly a slowly drifting pressure with noise, some full range and extremes
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 12)
			return SAMPLE_W'($urandom_range(0, 262143));
		if (r < 17)
			return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : '0;
		drift_base = drift_base + $urandom_range(0, 64) - 32;
		if (drift_base < 300)
			drift_base = 300;
		if (drift_base > 261800)
			drift_base = 261800;
		v = drift_base + $urandom_range(0, 512) - 256;
		return SAMPLE_W'(v);
	endfunction

	// entered and left at a falling edge; valid stays high for back-to-back items
	task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit typed,
			input logic [SAMPLE_W-1:0] typed_mean);
		int                  gap;
		logic [SAMPLE_W-1:0] predicted;
		gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(TDATA_W-SAMPLE_W){1'b0}}, smp};
		do
			@(posedge clk);
		while (!s_tready);
		predicted = window_push_mean(smp);
		mean_q.push_back(typed ? typed_mean : predicted);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (mean_q.size() != 0)
			@(negedge clk);
	endtask

	// receiver: random stalls, or a long hold counted here when asked
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
				rx_hold_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		logic [SAMPLE_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (mean_q.size() == 0) begin
				$error("trimmed_mean: no item pending, actual %0d", m_tdata[SAMPLE_W-1:0]);
				mismatch_count++;
			end else begin
				want = mean_q.pop_front();
				if (m_tdata[SAMPLE_W-1:0] !== want) begin
					$error("trimmed_mean: expected %0d, actual %0d", want,
						m_tdata[SAMPLE_W-1:0]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_CAP) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int tx_pct [4] = '{0, 68, 0, 30};
		int rx_pct [4] = '{0, 0, 68, 30};
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		tx_idle_pct    = 0;
		rx_stall_pct   = 0;
		rx_hold_req    = 1'b0;
		mismatch_count = 0;
		drift_base     = 131072;
		wr_slot        = 0;
		for (int i = 0; i < WIN; i++)
			window_model[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_sample(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].mean);
		drain_results();

		// output held off while items keep coming, so the input has to stall
		rx_hold_req = 1'b1;
		for (int i = 0; i < 30; i++)
			send_sample(pick_sample(), 1'b0, '0);
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct  = tx_pct[ph];
			rx_stall_pct = rx_pct[ph];
			for (int i = 0; i < PHASE_LEN; i++)
				send_sample(pick_sample(), 1'b0, '0);
			drain_results();
		end

		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sliding_window_trimmed_mean.f
hdl/swtm_pkg.sv
hdl/swtm_ctrl.sv
hdl/swtm_dp.sv
hdl/sliding_window_trimmed_mean.sv
dv/tb_top.sv
